/* src/tcpg_pkg.sv */
// ----------------------------------------------------------------------------
// tcpg_pkg: shared types and constants of the toggle compare PWM generator
// Field widths, reset values, operation codes and state machine encoding.
// ----------------------------------------------------------------------------
package tcpg_pkg;

    // default configuration
    localparam int P_CHANNELS  = 4;
    localparam int P_TICK_RATE = 2000000;
    localparam int P_DUTY_BITS = 12;

    // fixed field widths
    localparam int OP_W    = 3;
    localparam int CH_W    = 2;
    localparam int VALUE_W = 21;
    localparam int PINS_W  = 4;
    localparam int TIME_W  = 16;
    localparam int CNT_W   = 16;

    // stream bus widths
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = 8;

    // frequency floor and reset values
    localparam int FREQ_MIN     = 31;
    localparam int CMP_RESET    = 10;
    localparam int HIGH_RESET   = 10;
    localparam int LOW_RESET    = 1990;
    localparam int FREQ_RESET   = 1000;
    localparam int DUTY_RESET   = 2048;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_DUTY   = 3'd1,
        OP_FREQ   = 3'd2,
        OP_LEVEL  = 3'd3,
        OP_ENABLE = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

endpackage

/* src/tcpg_div.sv */
// ----------------------------------------------------------------------------
// tcpg_div: bit-serial restoring divider
// Divides a constant tick rate by a frequency, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcpg_div #(
    parameter int DIVIDEND = tcpg_pkg::P_TICK_RATE,
    parameter int Q_W      = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tcpg_pkg::VALUE_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [Q_W-1:0]               o_quotient
);

    localparam int DIV_W = $clog2(DIVIDEND + 1);
    localparam int CW    = $clog2(DIV_W + 1);
    localparam int VW    = tcpg_pkg::VALUE_W;

    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_quo;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {r_rem, r_num[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= DIV_W'(DIVIDEND);
            r_quo <= '0;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = Q_W'(r_quo);

endmodule

/* src/tcpg_mul.sv */
// ----------------------------------------------------------------------------
// tcpg_mul: bit-serial dual multiplier
// Forms (period*duty)>>DUTY_BITS and (period*~duty)>>DUTY_BITS, one duty
// bit per cycle, least significant first; dropped bits fall off the bottom.
// ----------------------------------------------------------------------------
module tcpg_mul #(
    parameter int PERIOD_W  = 16,
    parameter int DUTY_BITS = tcpg_pkg::P_DUTY_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [PERIOD_W-1:0]         i_period,
    input  logic [DUTY_BITS-1:0]        i_duty,
    output logic                        o_done,
    output logic [tcpg_pkg::TIME_W-1:0] o_high,
    output logic [tcpg_pkg::TIME_W-1:0] o_low
);

    localparam int CW = $clog2(DUTY_BITS + 1);

    logic [PERIOD_W-1:0]  r_per;
    logic [PERIOD_W-1:0]  r_acc_h;
    logic [PERIOD_W-1:0]  r_acc_l;
    logic [DUTY_BITS-1:0] r_dh;
    logic [DUTY_BITS-1:0] r_dl;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [PERIOD_W:0] sum_h;
    logic [PERIOD_W:0] sum_l;

    assign sum_h = {1'b0, r_acc_h} + (r_dh[0] ? {1'b0, r_per} : '0);
    assign sum_l = {1'b0, r_acc_l} + (r_dl[0] ? {1'b0, r_per} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DUTY_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_per   <= i_period;
            r_acc_h <= '0;
            r_acc_l <= '0;
            r_dh    <= i_duty;
            r_dl    <= ~i_duty;
        end else if (r_busy) begin
            // add, then halve: the accumulator keeps floor(partial / 2^k)
            r_acc_h <= sum_h[PERIOD_W:1];
            r_acc_l <= sum_l[PERIOD_W:1];
            r_dh    <= r_dh >> 1;
            r_dl    <= r_dl >> 1;
        end
    end

    assign o_done = r_done;
    assign o_high = tcpg_pkg::TIME_W'(r_acc_h);
    assign o_low  = tcpg_pkg::TIME_W'(r_acc_l);

endmodule

/* src/toggle_compare_pwm_generator_unit.sv */
// ----------------------------------------------------------------------------
// toggle_compare_pwm_generator_unit: output compare toggle PWM generator
// Ticks, level writes, enables and rejected writes: one transfer per cycle
//   when idle and the output is free; result registered the cycle after.
// Duty and frequency writes: the sequencer runs the serial divider (one
//   quotient bit per cycle), then the serial multiplier (one duty bit per
//   cycle), then waits for a free output register. Sync reset.
// ----------------------------------------------------------------------------
module toggle_compare_pwm_generator_unit #(
    parameter int CHANNELS  = tcpg_pkg::P_CHANNELS,
    parameter int TICK_RATE = tcpg_pkg::P_TICK_RATE,
    parameter int DUTY_BITS = tcpg_pkg::P_DUTY_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item: tdata = channel[1:0], value[22:2], zero pad[23]
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tcpg_pkg::S_DATA_W-1:0] i_s_tdata,
    // tuser = op[2:0]
    input  logic [tcpg_pkg::S_USER_W-1:0] i_s_tuser,
    // result item: tdata = pin_levels[3:0], write_rejected[4], zero pad[7:5]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tcpg_pkg::M_DATA_W-1:0] o_m_tdata
);

    localparam int VW          = tcpg_pkg::VALUE_W;
    localparam int TW          = tcpg_pkg::TIME_W;
    localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PERIOD_W    = $clog2(TICK_RATE / tcpg_pkg::FREQ_MIN + 1);
    localparam int PINS_VIEW_W = tcpg_pkg::PINS_W;
    localparam logic [VW-1:0] DUTY_MAX = VW'((1 << DUTY_BITS) - 1);
    localparam logic [VW-1:0] F_MIN    = VW'(tcpg_pkg::FREQ_MIN);
    localparam logic [VW-1:0] F_MAX    = VW'(TICK_RATE);

    // channel state
    logic [tcpg_pkg::CNT_W-1:0] r_cnt,  n_cnt;
    logic [TW-1:0]              r_cmp   [CHANNELS];
    logic [TW-1:0]              n_cmp   [CHANNELS];
    logic [TW-1:0]              r_high  [CHANNELS];
    logic [TW-1:0]              n_high  [CHANNELS];
    logic [TW-1:0]              r_low   [CHANNELS];
    logic [TW-1:0]              n_low   [CHANNELS];
    logic [VW-1:0]              r_freq  [CHANNELS];
    logic [VW-1:0]              n_freq  [CHANNELS];
    logic [DUTY_BITS-1:0]       r_duty  [CHANNELS];
    logic [DUTY_BITS-1:0]       n_duty  [CHANNELS];
    logic                       r_lowph [CHANNELS];
    logic                       n_lowph [CHANNELS];
    logic                       r_pwm   [CHANNELS];
    logic                       n_pwm   [CHANNELS];
    logic                       r_fix   [CHANNELS];
    logic                       n_fix   [CHANNELS];
    logic                       r_pin   [CHANNELS];
    logic                       n_pin   [CHANNELS];

    // control
    tcpg_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_ch, n_ch;
    logic             r_out_valid, n_out_valid;
    logic             r_rej, n_rej;

    // item decode
    tcpg_pkg::t_op             op;
    logic [tcpg_pkg::CH_W-1:0] ch_in;
    logic [IDX_W-1:0]          ch_idx;
    logic [VW-1:0]             val;
    logic                      ch_ok;
    logic                      in_xfer;
    logic                      out_free;
    logic                      go_calc;
    logic                      imm_load;

    // sequencer strobes
    logic div_start;
    logic div_done;
    logic mul_start;
    logic mul_done;
    logic time_we;
    logic done_load;

    logic [PERIOD_W-1:0]    period;
    logic [TW-1:0]          mul_high;
    logic [TW-1:0]          mul_low;
    logic [PINS_VIEW_W-1:0] pin_view;

    assign op      = tcpg_pkg::t_op'(i_s_tuser);
    assign ch_in   = i_s_tdata[tcpg_pkg::CH_W-1:0];
    assign val     = i_s_tdata[tcpg_pkg::CH_W +: VW];
    assign ch_idx  = IDX_W'(ch_in);
    assign ch_ok   = (32'(ch_in) < CHANNELS);
    assign in_xfer = i_s_tvalid && o_s_tready;

    // the output register may take a new result when empty or being drained
    assign out_free = !r_out_valid || i_m_tready;

    // ---------------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcpg_pkg::ST_IDLE: begin
                if (in_xfer && go_calc) n_state = tcpg_pkg::ST_LOAD;
            end
            tcpg_pkg::ST_LOAD: begin
                n_state = tcpg_pkg::ST_DIV;
            end
            tcpg_pkg::ST_DIV: begin
                if (div_done) n_state = tcpg_pkg::ST_MUL;
            end
            tcpg_pkg::ST_MUL: begin
                if (mul_done) n_state = tcpg_pkg::ST_DONE;
            end
            tcpg_pkg::ST_DONE: begin
                if (out_free) n_state = tcpg_pkg::ST_IDLE;
            end
            default: n_state = tcpg_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // sequencer: outputs
    // ---------------------------------------------------------------------
    always_comb begin
        o_s_tready = 1'b0;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        time_we    = 1'b0;
        done_load  = 1'b0;
        unique case (r_state)
            tcpg_pkg::ST_IDLE: o_s_tready = out_free;
            tcpg_pkg::ST_LOAD: div_start  = 1'b1;
            tcpg_pkg::ST_DIV:  mul_start  = div_done;
            tcpg_pkg::ST_MUL:  time_we    = mul_done;
            tcpg_pkg::ST_DONE: done_load  = out_free;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // channel datapath
    // ---------------------------------------------------------------------
    always_comb begin
        n_cnt   = r_cnt;
        n_cmp   = r_cmp;
        n_high  = r_high;
        n_low   = r_low;
        n_freq  = r_freq;
        n_duty  = r_duty;
        n_lowph = r_lowph;
        n_pwm   = r_pwm;
        n_fix   = r_fix;
        n_pin   = r_pin;
        n_ch    = r_ch;
        n_rej   = r_rej;
        go_calc = 1'b0;

        if (in_xfer) begin
            n_rej = 1'b0;
            n_ch  = ch_idx;
            case (op)
                tcpg_pkg::OP_TICK: begin
                    // serve every channel in the same tick
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (!r_pwm[i]) begin
                            n_pin[i] = r_fix[i];
                        end else if (r_cmp[i] == r_cnt) begin
                            n_pin[i]   = !r_pin[i];
                            n_cmp[i]   = r_cmp[i] + (r_lowph[i] ? r_low[i] : r_high[i]);
                            n_lowph[i] = !r_lowph[i];
                        end
                    end
                    n_cnt = r_cnt + 1'b1;
                end
                tcpg_pkg::OP_DUTY: begin
                    if (ch_ok) begin
                        if (val > DUTY_MAX) begin
                            n_rej = 1'b1;
                        end else begin
                            n_duty[ch_idx] = val[DUTY_BITS-1:0];
                            go_calc        = 1'b1;
                        end
                    end
                end
                tcpg_pkg::OP_FREQ: begin
                    if (ch_ok) begin
                        if (val < F_MIN) begin
                            n_freq[ch_idx] = F_MIN;
                        end else if (val > F_MAX) begin
                            n_freq[ch_idx] = F_MAX;
                        end else begin
                            n_freq[ch_idx] = val;
                        end
                        go_calc = 1'b1;
                    end
                end
                tcpg_pkg::OP_LEVEL: begin
                    if (ch_ok) begin
                        if (val > VW'(1)) begin
                            n_rej = 1'b1;
                        end else begin
                            n_fix[ch_idx] = val[0];
                            n_pwm[ch_idx] = 1'b0;
                            n_pin[ch_idx] = val[0];
                        end
                    end
                end
                tcpg_pkg::OP_ENABLE: begin
                    if (ch_ok) begin
                        n_pwm[ch_idx] = (val != '0);
                        if (val == '0) n_pin[ch_idx] = r_fix[ch_idx];
                    end
                end
                default: ;  // unknown op: leave everything as it is
            endcase
        end

        // store the recomputed times of the addressed channel
        if (time_we) begin
            n_high[r_ch] = mul_high;
            n_low[r_ch]  = mul_low;
            n_rej        = 1'b0;
        end
    end

    // results that need no arithmetic go straight to the output register
    assign imm_load = in_xfer && !go_calc;

    always_comb begin
        n_out_valid = r_out_valid;
        if (imm_load || done_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcpg_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cmp[i]   <= TW'(tcpg_pkg::CMP_RESET);
                r_high[i]  <= TW'(tcpg_pkg::HIGH_RESET);
                r_low[i]   <= TW'(tcpg_pkg::LOW_RESET);
                r_freq[i]  <= VW'(tcpg_pkg::FREQ_RESET);
                r_duty[i]  <= DUTY_BITS'(tcpg_pkg::DUTY_RESET);
                r_lowph[i] <= 1'b0;
                r_pwm[i]   <= 1'b0;
                r_fix[i]   <= 1'b0;
                r_pin[i]   <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_cmp       <= n_cmp;
            r_high      <= n_high;
            r_low       <= n_low;
            r_freq      <= n_freq;
            r_duty      <= n_duty;
            r_lowph     <= n_lowph;
            r_pwm       <= n_pwm;
            r_fix       <= n_fix;
            r_pin       <= n_pin;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_ch  <= n_ch;
        r_rej <= n_rej;
    end

    // ---------------------------------------------------------------------
    // serial arithmetic: period = TICK_RATE / f, then the two times
    // ---------------------------------------------------------------------
    tcpg_div #(
        .DIVIDEND (TICK_RATE),
        .Q_W      (PERIOD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (r_freq[r_ch]),
        .o_done     (div_done),
        .o_quotient (period)
    );

    tcpg_mul #(
        .PERIOD_W  (PERIOD_W),
        .DUTY_BITS (DUTY_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_period (period),
        .i_duty   (r_duty[r_ch]),
        .o_done   (mul_done),
        .o_high   (mul_high),
        .o_low    (mul_low)
    );

    // ---------------------------------------------------------------------
    // result: pins change only at an input transfer, and a transfer needs a
    // free output register, so the live pins always match the held result
    // ---------------------------------------------------------------------
    for (genvar g = 0; g < PINS_VIEW_W; g++) begin : g_pin
        if (g < CHANNELS) begin : g_live
            assign pin_view[g] = r_pin[g];
        end else begin : g_none
            assign pin_view[g] = 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_rej, pin_view};

endmodule

/* src/tcpg_checker.sv */
// ----------------------------------------------------------------------------
// tcpg_checker: port-level checks of the PWM generator
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module tcpg_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [tcpg_pkg::S_USER_W-1:0] i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [tcpg_pkg::M_DATA_W-1:0] o_m_tdata
);

    // a held result keeps its value until transferred
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // no input transfer while the output register is stuck
    a_block : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken with output stalled");

    // a tick yields a result on the next cycle, never flagged rejected
    a_tick : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == tcpg_pkg::OP_TICK)
        |=> o_m_tvalid && !o_m_tdata[4])
        else $error("tick result missing or flagged");

    // reset empties the output register
    a_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind toggle_compare_pwm_generator_unit tcpg_checker u_tcpg_checker (.*);
